// ===== sv/encoder_speed_pid_motor_drive_core_macros.svh =====
// assertion helpers for the core rtl file
`ifndef ENCODER_SPEED_PID_MOTOR_DRIVE_CORE_MACROS_SVH
`define ENCODER_SPEED_PID_MOTOR_DRIVE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ESPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ESPD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ESPD_ASSERT(lbl, prop, msg)
`define ESPD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== sv/espd_pkg.sv =====
package espd_pkg;

  localparam int DriveMax    = 1000;
  localparam int SpeedWindow = 10000;
  localparam int CountReset  = 32000;
  localparam int LimitReset  = 300;
  // width of the summed gain products
  localparam int SumW        = 36;

  typedef enum logic [2:0] {
    RegGainProp    = 3'd0,
    RegGainInteg   = 3'd1,
    RegGainDeriv   = 3'd2,
    RegGainFeedfwd = 3'd3,
    RegIntegLimit  = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [14:0] speed;
    logic signed [16:0] err;
    logic signed [15:0] acc;
    logic signed [17:0] derr;
  } pid_terms_t;

  typedef struct packed {
    logic [9:0] duty;
    logic       reverse;
  } drive_t;

endpackage

// ===== sv/espd_speed.sv =====
module espd_speed #(
  parameter int CounterBits = 16
) (
  input  logic [CounterBits-1:0] cnt_i,
  input  logic [CounterBits-1:0] prev_cnt_i,
  input  logic signed [14:0]     target_i,
  input  logic signed [15:0]     integ_i,
  input  logic signed [16:0]     prev_err_i,
  input  logic [14:0]            limit_i,
  output espd_pkg::pid_terms_t   terms_o
);

  localparam int DW = (CounterBits + 2 > 16) ? CounterBits + 2 : 16;

  logic signed [DW-1:0] win, modulus, diff, wrap1, wrap2, clamped;
  logic signed [16:0]   err;
  logic signed [17:0]   acc_sum, lim;
  logic signed [15:0]   acc;

  assign win     = DW'(espd_pkg::SpeedWindow);
  assign modulus = DW'(1) << CounterBits;
  assign diff    = $signed(DW'(cnt_i)) - $signed(DW'(prev_cnt_i));

  // the two wrap corrections apply one after the other
  always_comb begin
    wrap1 = (diff < -win) ? diff + modulus : diff;
    wrap2 = (wrap1 > win) ? wrap1 - modulus : wrap1;
    if (wrap2 > win) begin
      clamped = win;
    end else if (wrap2 < -win) begin
      clamped = -win;
    end else begin
      clamped = wrap2;
    end
  end

  assign err     = 17'(target_i) - 17'(clamped);
  assign acc_sum = 18'(integ_i) + 18'(err);
  assign lim     = $signed({3'b000, limit_i});

  always_comb begin
    if (acc_sum > lim) begin
      acc = lim[15:0];
    end else if (acc_sum < -lim) begin
      acc = 16'(-lim);
    end else begin
      acc = acc_sum[15:0];
    end
  end

  assign terms_o.speed = clamped[14:0];
  assign terms_o.err   = err;
  assign terms_o.acc   = acc;
  assign terms_o.derr  = 18'(err) - 18'(prev_err_i);

endmodule

// ===== sv/espd_sat.sv =====
module espd_sat #(
  parameter int GainFracBits = 8
) (
  input  logic signed [espd_pkg::SumW-1:0] sum_i,
  output espd_pkg::drive_t                 drive_o
);

  localparam int SW = espd_pkg::SumW;
  localparam logic [SW-1:0] Bias = SW'((64'(1) << GainFracBits) - 64'(1));

  logic signed [SW-1:0] biased, quot, dmax;
  logic signed [10:0]   drive;

  assign dmax = SW'(espd_pkg::DriveMax);
  // add 2^f-1 to negative sums so the shift truncates toward zero
  assign biased = sum_i + (sum_i[SW-1] ? $signed(Bias) : $signed(SW'(0)));
  assign quot   = biased >>> GainFracBits;

  always_comb begin
    if (quot > dmax) begin
      drive = dmax[10:0];
    end else if (quot < -dmax) begin
      drive = 11'(-dmax);
    end else begin
      drive = quot[10:0];
    end
  end

  assign drive_o.reverse = drive[10];
  assign drive_o.duty    = drive[10] ? 10'(-drive) : drive[9:0];

endmodule

// ===== sv/encoder_speed_pid_motor_drive_core.sv =====
// pipeline: an accepted item moves through the s0, s1, s2 and s3 registers and
// the output register; one item per cycle while out_ready_i does not stall the
// output; the encoder/integral/error state is updated as each item loads s1
// reset: pipeline empty, gains 0, integral limit 300, previous count 32000,
// integral and previous error 0
`include "encoder_speed_pid_motor_drive_core_macros.svh"

module encoder_speed_pid_motor_drive_core #(
  parameter int CounterBits  = 16,
  parameter int GainFracBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        encoder_count_i,
  input  logic signed [14:0] target_speed_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         duty_o,
  output logic               reverse_o,
  output logic signed [14:0] measured_speed_o
);

  localparam int SW = espd_pkg::SumW;

  logic signed [15:0] gain_prop_q, gain_integ_q, gain_deriv_q, gain_feedfwd_q;
  logic [14:0]        integ_limit_q;

  logic [CounterBits-1:0] prev_count_q;
  logic signed [15:0]     integ_q;
  logic signed [16:0]     prev_err_q;

  logic v0_q, v1_q, v2_q, v3_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3, rdyo;
  logic s1_load;

  logic [CounterBits+15:0] cnt_ext;
  logic [CounterBits-1:0]  s0_cnt_q;
  logic signed [14:0]      s0_tgt_q;

  espd_pkg::pid_terms_t terms, s1_q;
  logic signed [14:0]   s1_tgt_q;

  logic signed [32:0] prod_p_q;
  logic signed [32:0] prod_i_q;
  logic signed [33:0] prod_d_q;
  logic signed [30:0] prod_f_q;
  logic signed [14:0] s2_speed_q;

  logic signed [SW-1:0] sum_q;
  logic signed [14:0]   s3_speed_q;

  espd_pkg::drive_t drive;
  logic [9:0]         duty_q;
  logic               rev_q;
  logic signed [14:0] speed_out_q;

  // each stage takes a new item when empty or when its contents move on
  assign rdyo    = !vo_q || out_ready_i;
  assign rdy3    = !v3_q || rdyo;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign s1_load = rdy1 && v0_q;

  assign in_ready_o = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q    <= '0;
      gain_integ_q   <= '0;
      gain_deriv_q   <= '0;
      gain_feedfwd_q <= '0;
      integ_limit_q  <= 15'(espd_pkg::LimitReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        espd_pkg::RegGainProp:    gain_prop_q    <= cfg_data_i;
        espd_pkg::RegGainInteg:   gain_integ_q   <= cfg_data_i;
        espd_pkg::RegGainDeriv:   gain_deriv_q   <= cfg_data_i;
        espd_pkg::RegGainFeedfwd: gain_feedfwd_q <= cfg_data_i;
        espd_pkg::RegIntegLimit:  integ_limit_q  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q <= CounterBits'(espd_pkg::CountReset);
      integ_q      <= '0;
      prev_err_q   <= '0;
    end else if (s1_load) begin
      prev_count_q <= s0_cnt_q;
      integ_q      <= terms.acc;
      prev_err_q   <= terms.err;
    end
  end

  // counter sample taken at the configured counter width
  assign cnt_ext = {CounterBits'(0), encoder_count_i};

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      s0_cnt_q <= cnt_ext[CounterBits-1:0];
      s0_tgt_q <= target_speed_i;
    end
  end

  espd_speed #(
    .CounterBits(CounterBits)
  ) u_speed (
    .cnt_i     (s0_cnt_q),
    .prev_cnt_i(prev_count_q),
    .target_i  (s0_tgt_q),
    .integ_i   (integ_q),
    .prev_err_i(prev_err_q),
    .limit_i   (integ_limit_q),
    .terms_o   (terms)
  );

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q     <= terms;
      s1_tgt_q <= s0_tgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      prod_p_q   <= gain_prop_q * s1_q.err;
      prod_i_q   <= gain_integ_q * s1_q.acc;
      prod_d_q   <= gain_deriv_q * s1_q.derr;
      prod_f_q   <= gain_feedfwd_q * s1_tgt_q;
      s2_speed_q <= s1_q.speed;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      sum_q      <= SW'(prod_p_q) + SW'(prod_i_q) + SW'(prod_d_q) + SW'(prod_f_q);
      s3_speed_q <= s2_speed_q;
    end
  end

  espd_sat #(
    .GainFracBits(GainFracBits)
  ) u_sat (
    .sum_i  (sum_q),
    .drive_o(drive)
  );

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) begin
      duty_q      <= drive.duty;
      rev_q       <= drive.reverse;
      speed_out_q <= s3_speed_q;
    end
  end

  assign out_valid_o      = vo_q;
  assign duty_o           = duty_q;
  assign reverse_o        = rev_q;
  assign measured_speed_o = speed_out_q;

  `ESPD_ASSERT(a_duty_max, out_valid_o |-> (duty_o <= 10'(espd_pkg::DriveMax)), "duty over max")
  `ESPD_ASSERT_NEVER(a_zero_fwd, out_valid_o && reverse_o && (duty_o == '0), "reverse at zero duty")
  `ESPD_ASSERT(a_state_hold, !s1_load |=> ($stable(prev_count_q) && $stable(integ_q) && $stable(prev_err_q)), "state moved without item")
  `ESPD_ASSERT(a_speed_win, v1_q |-> ((s1_q.speed <= $signed(15'(espd_pkg::SpeedWindow))) && (s1_q.speed >= -$signed(15'(espd_pkg::SpeedWindow)))), "speed out of window")

endmodule
